// File: design/rde_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rde_pkg
// Shared widths, register indexes, reset values and types of the radix digit
// emitter.
// ----------------------------------------------------------------------------
package rde_pkg;

   localparam int VALUE_W   = 64;
   localparam int DIGIT_W   = 4;
   localparam int CHAR_W    = 8;
   localparam int TOTAL_W   = 32;
   localparam int RADIX_W   = 5;
   localparam int CSR_IDX_W = 2;
   localparam int BYTE_W    = 8;
   localparam int NCHUNK    = VALUE_W / BYTE_W;
   localparam int CHUNK_W   = $clog2(NCHUNK);
   localparam int NUM_BANKS = 2;
   localparam int BANK_CNT_W = $clog2(NUM_BANKS + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_RADIX      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHARS_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHARS_HIGH = 2'd2;

   localparam logic [RADIX_W-1:0] RADIX_RESET      = 5'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN        = 5'd2;
   localparam logic [VALUE_W-1:0] CHARS_LOW_RESET  = 64'h3736353433323130;
   localparam logic [VALUE_W-1:0] CHARS_HIGH_RESET = 64'h6665646362613938;

   typedef logic [DIGIT_W-1:0] digit_type;

   // One digit written into the digit stack by the front part.
   typedef struct packed {
      logic      en;
      logic      bank;
      digit_type digit;
   } stack_wr_type;

   function automatic logic [CHAR_W-1:0] char_of_digit(
      input digit_type          d,
      input logic [VALUE_W-1:0] chars_low,
      input logic [VALUE_W-1:0] chars_high
   );
      logic [2*VALUE_W-1:0] tbl;
      tbl = {chars_high, chars_low};
      return tbl[{d, 3'b000} +: CHAR_W];
   endfunction

endpackage
`default_nettype wire

// File: design/radix_digit_emitter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// radix_digit_emitter
// Converts unsigned 64-bit values into digit characters of a configurable
// base, most significant digit first, without leading zeros.
// ----------------------------------------------------------------------------
// Values enter through a queue-style port (req_push / req_full) and leave as
// one result per character (rsp_empty / rsp_pop), each with a last flag on
// the least significant digit and the running character count since reset.
// The csr_ port writes the radix and the two halves of the character table;
// it is always ready, and writes are meant for times when the block is idle.
// The digit generator does one byte of long division per cycle and starts at
// the leading nonzero byte, so a digit takes longer the higher that byte lies;
// a full 64-bit value has about 20 digits in base 10. The emitter then gives
// one character per cycle while the receiver keeps up, from a two-bank digit
// stack, so the generator works on the next value while the previous one is
// still being emitted. After the last digit is found, the first character
// passes the descriptor queue, a stack read and the result register.
// If the receiver stalls, the emitter holds its result register and the
// generator stops once both stack banks are taken; req_full then stays high.
// Reset empties both sides, clears the character count and restores base
// ten with the table "0123456789abcdef".
// ----------------------------------------------------------------------------
module radix_digit_emitter import rde_pkg::*; #(
   parameter int MAX_DIGITS = 64,
   parameter int MAX_RADIX  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [VALUE_W-1:0]   req_value,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [CHAR_W-1:0]    rsp_character,
   output logic                 rsp_is_last,
   output logic [TOTAL_W-1:0]   rsp_total_emitted,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [VALUE_W-1:0]   csr_wdata
);

   localparam int IDX_W  = $clog2(MAX_DIGITS);
   localparam int DESC_W = IDX_W + 1;

   logic [RADIX_W-1:0] radix_ff;
   logic [VALUE_W-1:0] chars_low_ff;
   logic [VALUE_W-1:0] chars_high_ff;
   logic [RADIX_W-1:0] radix_eff;

   stack_wr_type         stack_wr;
   logic [IDX_W-1:0]     stack_wr_idx;
   logic                 desc_push;
   logic                 desc_push_bank;
   logic [IDX_W-1:0]     desc_push_last;
   logic [DESC_W-1:0]    desc_pop_data;
   logic                 desc_pop;
   logic                 desc_empty;
   logic [BANK_CNT_W-1:0] desc_count;
   logic                 back_busy;
   logic                 slot_free;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff      <= RADIX_RESET;
         chars_low_ff  <= CHARS_LOW_RESET;
         chars_high_ff <= CHARS_HIGH_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RADIX:      radix_ff      <= csr_wdata[RADIX_W-1:0];
            CSR_CHARS_LOW:  chars_low_ff  <= csr_wdata;
            CSR_CHARS_HIGH: chars_high_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      radix_eff = radix_ff;
      if (radix_ff < RADIX_MIN) begin
         radix_eff = RADIX_MIN;
      end else if (radix_ff > RADIX_W'(MAX_RADIX)) begin
         radix_eff = RADIX_W'(MAX_RADIX);
      end
   end

   // Each number in the queue or in the emitter holds one stack bank.
   assign slot_free = ({1'b0, desc_count} + {{BANK_CNT_W{1'b0}}, back_busy})
                      < (BANK_CNT_W + 1)'(NUM_BANKS);

   rde_front #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_value    (req_value),
      .radix        (radix_eff),
      .slot_free    (slot_free),
      .stack_wr     (stack_wr),
      .stack_wr_idx (stack_wr_idx),
      .desc_push    (desc_push),
      .desc_bank    (desc_push_bank),
      .desc_last    (desc_push_last)
   );

   rde_queue #(
      .DATA_W (DESC_W),
      .DEPTH  (NUM_BANKS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_push),
      .push_data ({desc_push_bank, desc_push_last}),
      .pop       (desc_pop),
      .pop_data  (desc_pop_data),
      .empty     (desc_empty),
      .count     (desc_count)
   );

   rde_back #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .stack_wr          (stack_wr),
      .stack_wr_idx      (stack_wr_idx),
      .desc_empty        (desc_empty),
      .desc_bank         (desc_pop_data[DESC_W-1]),
      .desc_last         (desc_pop_data[IDX_W-1:0]),
      .desc_pop          (desc_pop),
      .busy              (back_busy),
      .chars_low         (chars_low_ff),
      .chars_high        (chars_high_ff),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_character     (rsp_character),
      .rsp_is_last       (rsp_is_last),
      .rsp_total_emitted (rsp_total_emitted)
   );

endmodule
`default_nettype wire

// File: design/rde_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rde_queue
// Small FIFO of finished-number descriptors between the digit generator and
// the character emitter.
// ----------------------------------------------------------------------------
module rde_queue import rde_pkg::*; #(
   parameter int DATA_W = 7,
   parameter int DEPTH  = 2,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty,
   output logic [CNT_W-1:0]  count
);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = entry_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && count_ff == CNT_W'(DEPTH)))
      else $error("descriptor queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && count_ff == '0))
      else $error("descriptor queue read while empty");

endmodule
`default_nettype wire

// File: design/rde_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rde_front
// Digit generator: accepts a value and divides it repeatedly by the radix,
// one byte of long division per cycle, writing the remainders into one bank
// of the digit stack. A finished number is handed on as a descriptor.
// ----------------------------------------------------------------------------
module rde_front import rde_pkg::*; #(
   parameter int MAX_DIGITS = 64,
   localparam int IDX_W = $clog2(MAX_DIGITS)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [VALUE_W-1:0] req_value,
   input  logic [RADIX_W-1:0] radix,
   input  logic               slot_free,
   output stack_wr_type       stack_wr,
   output logic [IDX_W-1:0]   stack_wr_idx,
   output logic               desc_push,
   output logic               desc_bank,
   output logic [IDX_W-1:0]   desc_last
);

   localparam logic F_IDLE = 1'b0;
   localparam logic F_DIV  = 1'b1;

   logic               state_ff, state_in;
   logic               bank_ff, bank_in;
   logic [VALUE_W-1:0] v_ff, v_in;
   logic [VALUE_W-1:0] q_ff, q_in;
   digit_type          rem_ff, rem_in;
   logic [CHUNK_W-1:0] chunk_ff, chunk_in;
   logic [CHUNK_W-1:0] top_ff, top_in;
   logic               qtop_zero_ff, qtop_zero_in;
   logic [IDX_W-1:0]   n_ff, n_in;

   logic               accept;
   logic [BYTE_W-1:0]  byte_in;
   logic [BYTE_W-1:0]  qbyte;
   digit_type          rem_next;
   logic [RADIX_W-1:0] acc;
   logic [VALUE_W-1:0] q_next;
   logic               last_chunk;
   logic               done_digit;
   logic               finish;
   logic               zero_at_top;
   logic [CHUNK_W-1:0] next_top;

   function automatic logic [CHUNK_W-1:0] top_chunk(input logic [VALUE_W-1:0] v);
      logic [CHUNK_W-1:0] t;
      t = '0;
      for (int i = 0; i < NCHUNK; i++) begin
         if (v[i*BYTE_W +: BYTE_W] != '0) begin
            t = CHUNK_W'(i);
         end
      end
      return t;
   endfunction

   assign req_full = (state_ff == F_DIV) || !slot_free;
   assign accept   = req_push && !req_full;

   // Eight restoring steps of long division; the remainder stays below the
   // radix, so each step is a five-bit compare and subtract.
   always_comb begin
      byte_in  = v_ff[{chunk_ff, 3'b000} +: BYTE_W];
      rem_next = rem_ff;
      qbyte    = '0;
      acc      = '0;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
         acc = {rem_next, byte_in[i]};
         if (acc >= radix) begin
            acc      = acc - radix;
            qbyte[i] = 1'b1;
         end
         rem_next = acc[DIGIT_W-1:0];
      end
      q_next = q_ff;
      q_next[{chunk_ff, 3'b000} +: BYTE_W] = qbyte;
   end

   assign last_chunk = (chunk_ff == '0);
   assign done_digit = (state_ff == F_DIV) && last_chunk;
   assign finish     = done_digit &&
                       ((q_next == '0) || (n_ff == IDX_W'(MAX_DIGITS - 1)));

   // Dividing by at most sixteen drops at most four bits, so the leading
   // byte of the quotient is the old one or the one below it.
   assign zero_at_top = (chunk_ff == top_ff) ? (qbyte == '0) : qtop_zero_ff;
   assign next_top    = (zero_at_top && top_ff != '0) ? top_ff - CHUNK_W'(1) : top_ff;

   always_comb begin
      state_in     = state_ff;
      bank_in      = bank_ff;
      v_in         = v_ff;
      q_in         = q_ff;
      rem_in       = rem_ff;
      chunk_in     = chunk_ff;
      top_in       = top_ff;
      qtop_zero_in = qtop_zero_ff;
      n_in         = n_ff;
      if (accept) begin
         state_in = F_DIV;
         v_in     = req_value;
         q_in     = '0;
         rem_in   = '0;
         chunk_in = top_chunk(req_value);
         top_in   = top_chunk(req_value);
         n_in     = '0;
      end else if (state_ff == F_DIV) begin
         q_in   = q_next;
         rem_in = rem_next;
         if (chunk_ff == top_ff) begin
            qtop_zero_in = (qbyte == '0);
         end
         if (!last_chunk) begin
            chunk_in = chunk_ff - CHUNK_W'(1);
         end else if (finish) begin
            state_in = F_IDLE;
            bank_in  = !bank_ff;
         end else begin
            v_in     = q_next;
            q_in     = '0;
            rem_in   = '0;
            chunk_in = next_top;
            top_in   = next_top;
            n_in     = n_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         bank_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         bank_ff  <= bank_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff         <= v_in;
      q_ff         <= q_in;
      rem_ff       <= rem_in;
      chunk_ff     <= chunk_in;
      top_ff       <= top_in;
      qtop_zero_ff <= qtop_zero_in;
      n_ff         <= n_in;
   end

   assign stack_wr.en    = done_digit;
   assign stack_wr.bank  = bank_ff;
   assign stack_wr.digit = rem_next;
   assign stack_wr_idx   = n_ff;
   assign desc_push      = finish;
   assign desc_bank      = bank_ff;
   assign desc_last      = n_ff;

   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == F_DIV) |-> ({1'b0, rem_ff} < radix))
      else $error("partial remainder not below the radix");

endmodule
`default_nettype wire

// File: design/rde_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rde_back
// Character emitter: owns the two-bank digit stack, takes descriptors of
// finished numbers and reads their digits back most significant first,
// mapping each to a character in the result register.
// ----------------------------------------------------------------------------
module rde_back import rde_pkg::*; #(
   parameter int MAX_DIGITS = 64,
   localparam int IDX_W  = $clog2(MAX_DIGITS),
   localparam int ADDR_W = IDX_W + 1
) (
   input  logic               clock,
   input  logic               reset,
   input  stack_wr_type       stack_wr,
   input  logic [IDX_W-1:0]   stack_wr_idx,
   input  logic               desc_empty,
   input  logic               desc_bank,
   input  logic [IDX_W-1:0]   desc_last,
   output logic               desc_pop,
   output logic               busy,
   input  logic [VALUE_W-1:0] chars_low,
   input  logic [VALUE_W-1:0] chars_high,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [CHAR_W-1:0]  rsp_character,
   output logic               rsp_is_last,
   output logic [TOTAL_W-1:0] rsp_total_emitted
);

   localparam logic B_IDLE = 1'b0;
   localparam logic B_EMIT = 1'b1;

   digit_type          stack_mem [2**ADDR_W];
   digit_type          rdata_ff;

   logic               state_ff, state_in;
   logic               bank_ff, bank_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff, last_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   logic               slot_free;
   logic               start;
   logic               emit;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;

   assign slot_free = !out_valid_ff || rsp_pop;
   assign start     = (state_ff == B_IDLE) && !desc_empty;
   assign emit      = (state_ff == B_EMIT) && slot_free;
   assign rd_en     = start || (emit && idx_ff != '0);
   assign rd_addr   = start ? {desc_bank, desc_last} : {bank_ff, idx_ff - IDX_W'(1)};

   always_ff @(posedge clock) begin
      if (stack_wr.en) begin
         stack_mem[{stack_wr.bank, stack_wr_idx}] <= stack_wr.digit;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= stack_mem[rd_addr];
      end
   end

   // The read data stays put while the result register is stalled, since no
   // new read is issued until the current digit has gone out.
   always_comb begin
      state_in     = state_ff;
      bank_in      = bank_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      total_in     = total_ff;
      if (start) begin
         state_in = B_EMIT;
         bank_in  = desc_bank;
         idx_in   = desc_last;
      end
      if (emit) begin
         out_valid_in = 1'b1;
         char_in      = char_of_digit(rdata_ff, chars_low, chars_high);
         last_in      = (idx_ff == '0);
         total_in     = total_ff + TOTAL_W'(1);
         if (idx_ff == '0) begin
            state_in = B_IDLE;
         end else begin
            idx_in = idx_ff - IDX_W'(1);
         end
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
         total_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         total_ff     <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      bank_ff <= bank_in;
      idx_ff  <= idx_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign desc_pop          = start;
   assign busy              = (state_ff == B_EMIT);
   assign rsp_empty         = !out_valid_ff;
   assign rsp_character     = char_ff;
   assign rsp_is_last       = last_ff;
   assign rsp_total_emitted = total_ff;

   a_total_steps: assert property (@(posedge clock) disable iff (reset)
      emit |=> (total_ff == $past(total_ff) + TOTAL_W'(1)))
      else $error("running total did not advance by one on a character");

endmodule
`default_nettype wire
